FILE: design/krpc_pkg.sv
// Shared types, constants and popcount function for the KING-robust pair counter.
`timescale 1ns / 1ps
package krpc_pkg;

	localparam int WORD_W      = 64;
	localparam int LANE_BYTES  = 8;
	localparam int CNT_W       = 7;
	localparam int TOT_W       = 32;
	localparam int BCNT_W      = 4;

	// per-word counts handed from front to back
	typedef struct packed {
		logic [CNT_W-1:0] opp;
		logic [CNT_W-1:0] scored;
		logic [CNT_W-1:0] hetd;
		logic [CNT_W-1:0] hom1;
		logic [CNT_W-1:0] hom2;
		logic             last;
	} word_cnt_t;

	// balanced adder tree, six levels deep
	function automatic logic [CNT_W-1:0] popcnt64(input logic [WORD_W-1:0] v);
		logic [1:0] l1 [32];
		logic [2:0] l2 [16];
		logic [3:0] l3 [8];
		logic [4:0] l4 [4];
		logic [5:0] l5 [2];
		for (int i = 0; i < 32; i++) begin
			l1[i] = 2'(v[2*i]) + 2'(v[2*i+1]);
		end
		for (int i = 0; i < 16; i++) begin
			l2[i] = 3'(l1[2*i]) + 3'(l1[2*i+1]);
		end
		for (int i = 0; i < 8; i++) begin
			l3[i] = 4'(l2[2*i]) + 4'(l2[2*i+1]);
		end
		for (int i = 0; i < 4; i++) begin
			l4[i] = 5'(l3[2*i]) + 5'(l3[2*i+1]);
		end
		for (int i = 0; i < 2; i++) begin
			l5[i] = 6'(l4[2*i]) + 6'(l4[2*i+1]);
		end
		return CNT_W'(l5[0]) + CNT_W'(l5[1]);
	endfunction

endpackage

FILE: design/krpc_front.sv
// Front stage: locus classification, byte masking and per-word popcounts.
`timescale 1ns / 1ps
module krpc_front #(
	parameter int WORD_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [krpc_pkg::WORD_W-1:0]   s1_plane_a,
	input  logic [krpc_pkg::WORD_W-1:0]   s1_plane_b,
	input  logic [krpc_pkg::WORD_W-1:0]   s2_plane_a,
	input  logic [krpc_pkg::WORD_W-1:0]   s2_plane_b,
	input  logic [krpc_pkg::BCNT_W-1:0]   byte_count,
	input  logic                          last_word,
	output logic                          q_wr,
	output krpc_pkg::word_cnt_t           q_wdata,
	input  logic                          q_full
);
	import krpc_pkg::*;

	logic [WORD_W-1:0] lane_mask;
	logic [WORD_W-1:0] scored;
	logic [WORD_W-1:0] opp;
	logic [WORD_W-1:0] hetd;
	logic [WORD_W-1:0] hom1;
	logic [WORD_W-1:0] hom2;
	logic              accept;
	logic              valid_s1;
	word_cnt_t         cnt_s1;

	// byte j counts when both byte_count and WORD_BYTES exceed j
	always_comb begin
		for (int j = 0; j < LANE_BYTES; j++) begin
			lane_mask[j*8 +: 8] = {8{(int'(byte_count) > j) && (WORD_BYTES > j)}};
		end
	end

	assign scored = (s1_plane_a | ~s1_plane_b) & (s2_plane_a | ~s2_plane_b) & lane_mask;
	assign opp    = (s1_plane_a ^ s2_plane_a) & (s1_plane_b ^ s2_plane_b) & scored;
	assign hetd   = (s1_plane_a ^ s1_plane_b ^ s2_plane_a ^ s2_plane_b) & scored;
	assign hom1   = s1_plane_a & ~s1_plane_b & scored;
	assign hom2   = s2_plane_a & ~s2_plane_b & scored;

	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_wr   = valid_s1 && !q_full;
	assign q_wdata = cnt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_wr) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cnt_s1.opp    <= popcnt64(opp);
			cnt_s1.scored <= popcnt64(scored);
			cnt_s1.hetd   <= popcnt64(hetd);
			cnt_s1.hom1   <= popcnt64(hom1);
			cnt_s1.hom2   <= popcnt64(hom2);
			cnt_s1.last   <= last_word;
		end
	end

endmodule

FILE: design/krpc_queue.sv
// Short queue of per-word counts between front and back.
`timescale 1ns / 1ps
module krpc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr,
	input  krpc_pkg::word_cnt_t wdata,
	output logic                full,
	input  logic                rd,
	output krpc_pkg::word_cnt_t rdata,
	output logic                not_empty
);
	import krpc_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	word_cnt_t        mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full      = (count_q == (PTR_W+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rdata     = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PTR_W+1)'(wr) - (PTR_W+1)'(rd);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(wr && full) && !(rd && !not_empty))
		else $error("queue overrun or underrun");

endmodule

FILE: design/krpc_back.sv
// Back stage: running totals and the result register.
`timescale 1ns / 1ps
module krpc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  krpc_pkg::word_cnt_t          q_rdata,
	output logic                         q_rd,
	output logic                         empty,
	input  logic                         pop,
	output logic [krpc_pkg::TOT_W-1:0]   ibs0_total,
	output logic [krpc_pkg::TOT_W-1:0]   loci_total,
	output logic [krpc_pkg::TOT_W-1:0]   sumsq_total,
	output logic [krpc_pkg::TOT_W-1:0]   first_hom_total,
	output logic [krpc_pkg::TOT_W-1:0]   second_hom_total
);
	import krpc_pkg::*;

	logic [TOT_W-1:0] zero_share_acc_q;
	logic [TOT_W-1:0] scored_acc_q;
	logic [TOT_W-1:0] sumsq_acc_q;
	logic [TOT_W-1:0] first_hom_acc_q;
	logic [TOT_W-1:0] second_hom_acc_q;
	logic [TOT_W-1:0] zero_share_nxt;
	logic [TOT_W-1:0] scored_nxt;
	logic [TOT_W-1:0] sumsq_nxt;
	logic [TOT_W-1:0] first_hom_nxt;
	logic [TOT_W-1:0] second_hom_nxt;
	logic [CNT_W+2:0] sumsq_inc;
	logic             out_valid_q;
	logic             take;

	// het + 4*ibs0 folded per word
	assign sumsq_inc = (CNT_W+3)'(q_rdata.hetd) + {q_rdata.opp, 2'b00};

	assign zero_share_nxt = zero_share_acc_q + TOT_W'(q_rdata.opp);
	assign scored_nxt     = scored_acc_q + TOT_W'(q_rdata.scored);
	assign sumsq_nxt      = sumsq_acc_q + TOT_W'(sumsq_inc);
	assign first_hom_nxt  = first_hom_acc_q + TOT_W'(q_rdata.hom1);
	assign second_hom_nxt = second_hom_acc_q + TOT_W'(q_rdata.hom2);

	assign take  = q_valid && (!q_rdata.last || !out_valid_q || pop);
	assign q_rd  = take;
	assign empty = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_share_acc_q <= '0;
			scored_acc_q     <= '0;
			sumsq_acc_q      <= '0;
			first_hom_acc_q  <= '0;
			second_hom_acc_q <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (take && q_rdata.last) begin
				zero_share_acc_q <= '0;
				scored_acc_q     <= '0;
				sumsq_acc_q      <= '0;
				first_hom_acc_q  <= '0;
				second_hom_acc_q <= '0;
				out_valid_q      <= 1'b1;
			end else begin
				if (take) begin
					zero_share_acc_q <= zero_share_nxt;
					scored_acc_q     <= scored_nxt;
					sumsq_acc_q      <= sumsq_nxt;
					first_hom_acc_q  <= first_hom_nxt;
					second_hom_acc_q <= second_hom_nxt;
				end
				if (pop) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && q_rdata.last) begin
			ibs0_total       <= zero_share_nxt;
			loci_total       <= scored_nxt;
			sumsq_total      <= sumsq_nxt;
			first_hom_total  <= first_hom_nxt;
			second_hom_total <= second_hom_nxt;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(take && q_rdata.last) |=> (out_valid_q && zero_share_acc_q == '0 &&
			scored_acc_q == '0 && sumsq_acc_q == '0))
		else $error("totals not emitted and cleared on last item");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> (out_valid_q && $stable(loci_total) &&
			$stable(sumsq_total) && $stable(ibs0_total)))
		else $error("waiting result overwritten");

	assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_rdata.last && out_valid_q && !pop) |-> !take)
		else $error("last item taken while result slot busy");

endmodule

FILE: design/king_robust_pair_counter.sv
// Top level of the KING-robust pair counter.
//
//  channel  | handshake         | payload
//  ---------+-------------------+--------------------------------------------------
//  input    | push / full       | s1/s2 plane a,b (64 each), byte_count, last_word
//  result   | pop / empty       | ibs0, loci, sumsq, first_hom, second_hom totals
//
// One item per cycle while the count queue has room; the popcount and accumulate
// stages are each registered, with the count queue between them. A four-entry
// count queue lets the front keep taking items while the result register waits
// for pop. arst_n clears the running totals and leaves both sides empty.
`timescale 1ns / 1ps
module king_robust_pair_counter #(
	parameter int WORD_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [krpc_pkg::WORD_W-1:0]   s1_plane_a,
	input  logic [krpc_pkg::WORD_W-1:0]   s1_plane_b,
	input  logic [krpc_pkg::WORD_W-1:0]   s2_plane_a,
	input  logic [krpc_pkg::WORD_W-1:0]   s2_plane_b,
	input  logic [krpc_pkg::BCNT_W-1:0]   byte_count,
	input  logic                          last_word,
	output logic                          empty,
	input  logic                          pop,
	output logic [krpc_pkg::TOT_W-1:0]    ibs0_total,
	output logic [krpc_pkg::TOT_W-1:0]    loci_total,
	output logic [krpc_pkg::TOT_W-1:0]    sumsq_total,
	output logic [krpc_pkg::TOT_W-1:0]    first_hom_total,
	output logic [krpc_pkg::TOT_W-1:0]    second_hom_total
);
	import krpc_pkg::*;

	logic      q_wr;
	logic      q_full;
	logic      q_rd;
	logic      q_valid;
	word_cnt_t q_wdata;
	word_cnt_t q_rdata;

	krpc_front #(
		.WORD_BYTES(WORD_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.s1_plane_a(s1_plane_a),
		.s1_plane_b(s1_plane_b),
		.s2_plane_a(s2_plane_a),
		.s2_plane_b(s2_plane_b),
		.byte_count(byte_count),
		.last_word (last_word),
		.q_wr      (q_wr),
		.q_wdata   (q_wdata),
		.q_full    (q_full)
	);

	krpc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (q_wr),
		.wdata    (q_wdata),
		.full     (q_full),
		.rd       (q_rd),
		.rdata    (q_rdata),
		.not_empty(q_valid)
	);

	krpc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_rdata         (q_rdata),
		.q_rd            (q_rd),
		.empty           (empty),
		.pop             (pop),
		.ibs0_total      (ibs0_total),
		.loci_total      (loci_total),
		.sumsq_total     (sumsq_total),
		.first_hom_total (first_hom_total),
		.second_hom_total(second_hom_total)
	);

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the KING-robust pair counter: directed and random word streams.
`timescale 1ns / 1ps
module testbench;
	import krpc_pkg::*;

	localparam int WORD_BYTES   = 8;
	localparam int ITEM_TARGET  = 1900;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 20;

	// [0] ibs0, [1] loci, [2] sumsq, [3] first hom, [4] second hom
	typedef logic [4:0][TOT_W-1:0] totals_t;

	class pair_tally_board;
		logic [TOT_W-1:0] ibs0_acc, loci_acc, het_acc, hom1_acc, hom2_acc;
		totals_t awaiting[$];
		int errors;

		function new();
			clear();
			errors = 0;
		endfunction

		function void clear();
			ibs0_acc = '0;
			loci_acc = '0;
			het_acc  = '0;
			hom1_acc = '0;
			hom2_acc = '0;
		endfunction

		function void note_word(logic [WORD_W-1:0] s1a, logic [WORD_W-1:0] s1b,
					logic [WORD_W-1:0] s2a, logic [WORD_W-1:0] s2b,
					logic [BCNT_W-1:0] nbytes, logic last);
			logic [WORD_W-1:0] lanes, scored, opp, hetd, hom1, hom2;
			int lim;
			totals_t t;
			lim = (int'(nbytes) > WORD_BYTES) ? WORD_BYTES : int'(nbytes);
			lanes = (lim >= LANE_BYTES) ? '1 : (WORD_W'(1) << (lim * 8)) - WORD_W'(1);
			scored = (s1a | ~s1b) & (s2a | ~s2b) & lanes;
			opp    = (s1a ^ s2a) & (s1b ^ s2b) & scored;
			hetd   = ((s1a ^ s1b) ^ (s2a ^ s2b)) & scored;
			hom1   = s1a & ~s1b & scored;
			hom2   = s2a & ~s2b & scored;
			ibs0_acc += TOT_W'($countones(opp));
			loci_acc += TOT_W'($countones(scored));
			het_acc  += TOT_W'($countones(hetd));
			hom1_acc += TOT_W'($countones(hom1));
			hom2_acc += TOT_W'($countones(hom2));
			if (last) begin
				t[0] = ibs0_acc;
				t[1] = loci_acc;
				t[2] = het_acc + (ibs0_acc << 2);
				t[3] = hom1_acc;
				t[4] = hom2_acc;
				awaiting.push_back(t);
				clear();
			end
		endfunction

		task check_totals(totals_t got);
			string field_names[5];
			totals_t want;
			field_names = '{"ibs0_total", "loci_total", "sumsq_total",
					"first_hom_total", "second_hom_total"};
			if (awaiting.size() == 0) begin
				report_mismatch("result with no pending pair");
				return;
			end
			want = awaiting.pop_front();
			for (int i = 0; i < 5; i++) begin
				if (got[i] !== want[i])
					report_mismatch($sformatf("%s got %0d want %0d",
						field_names[i], got[i], want[i]));
			end
		endtask

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic push, pop;
	logic full, empty;
	logic [WORD_W-1:0] s1_plane_a, s1_plane_b, s2_plane_a, s2_plane_b;
	logic [BCNT_W-1:0] byte_count;
	logic last_word;
	logic [TOT_W-1:0] ibs0_total, loci_total, sumsq_total, first_hom_total, second_hom_total;

	pair_tally_board board;
	int items_sent;
	int results_seen;
	bit sender_calm;
	bit receiver_calm;

	king_robust_pair_counter #(.WORD_BYTES(WORD_BYTES)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.s1_plane_a(s1_plane_a),
		.s1_plane_b(s1_plane_b),
		.s2_plane_a(s2_plane_a),
		.s2_plane_b(s2_plane_b),
		.byte_count(byte_count),
		.last_word(last_word),
		.empty(empty),
		.pop(pop),
		.ibs0_total(ibs0_total),
		.loci_total(loci_total),
		.sumsq_total(sumsq_total),
		.first_hom_total(first_hom_total),
		.second_hom_total(second_hom_total)
	);

	always #2 clk = ~clk;

	function automatic int pick_gap(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic send_word(logic [WORD_W-1:0] s1a, logic [WORD_W-1:0] s1b,
				logic [WORD_W-1:0] s2a, logic [WORD_W-1:0] s2b,
				logic [BCNT_W-1:0] nbytes, logic last);
		int gap;
		gap = pick_gap(sender_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s1_plane_a <= s1a;
		s1_plane_b <= s1b;
		s2_plane_a <= s2a;
		s2_plane_b <= s2b;
		byte_count <= nbytes;
		last_word  <= last;
		push       <= 1'b1;
		do @(posedge clk); while (full);
		board.note_word(s1a, s1b, s2a, s2b, nbytes, last);
		items_sent++;
		if (items_sent % 64 == 0)
			sender_calm = ($urandom_range(0, 3) == 0);
	endtask

	task automatic send_random_pair(int len);
		logic [WORD_W-1:0] s1a, s1b, s2a, s2b;
		logic [BCNT_W-1:0] nbytes;
		int mode;
		for (int w = 0; w < len; w++) begin
			mode = $urandom_range(0, 9);
			s1a = rand_word();
			s1b = rand_word();
			s2a = rand_word();
			s2b = rand_word();
			case (mode)
				0: begin
					s2a = s1a;
					s2b = s1b;
				end
				1, 2: begin
					// few missing loci
					s1b = s1b & rand_word() & rand_word();
					s2b = s2b & rand_word() & rand_word();
				end
				3, 4: begin
					// related pair: sample two mostly follows sample one
					s2a = s1a ^ (rand_word() & rand_word() & rand_word());
					s2b = s1b ^ (rand_word() & rand_word() & rand_word());
				end
				default: ;
			endcase
			nbytes = ($urandom_range(0, 9) < 8) ? BCNT_W'(8) : BCNT_W'($urandom_range(0, 15));
			send_word(s1a, s1b, s2a, s2b, nbytes, w == len - 1);
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		push       = 1'b0;
		pop        = 1'b0;
		s1_plane_a = '0;
		s1_plane_b = '0;
		s2_plane_a = '0;
		s2_plane_b = '0;
		byte_count = '0;
		last_word  = 1'b0;
		board      = new();
		items_sent = 0;
		sender_calm = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word('0, '0, '0, '0, 4'd8, 1'b1);
		send_word('1, '1, '1, '1, 4'd8, 1'b1);
		send_word('0, '0, '1, '1, 4'd8, 1'b1);
		send_word('1, '0, '0, '1, 4'd8, 1'b1);
		send_word('1, '0, '1, '0, 4'd15, 1'b1);
		send_word(rand_word(), rand_word(), rand_word(), rand_word(), 4'd0, 1'b1);
		send_word(rand_word(), rand_word(), rand_word(), rand_word(), 4'd0, 1'b0);
		send_word(rand_word(), rand_word(), rand_word(), rand_word(), 4'd8, 1'b0);
		send_word(rand_word(), rand_word(), rand_word(), rand_word(), 4'd5, 1'b1);
		for (int n = 1; n < 16; n++)
			send_word(rand_word(), rand_word(), rand_word(), rand_word(),
				BCNT_W'(n), n % 3 == 0);
		send_word(rand_word(), rand_word(), rand_word(), rand_word(), 4'd8, 1'b1);

		while (items_sent < ITEM_TARGET)
			send_random_pair(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
				: $urandom_range(1, 12));

		push <= 1'b0;
		while (board.awaiting.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		int stall_left;
		stall_left    = 0;
		results_seen  = 0;
		receiver_calm = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				board.check_totals({second_hom_total, first_hom_total, sumsq_total,
					loci_total, ibs0_total});
				results_seen++;
				if (results_seen % 50 == 0)
					receiver_calm = ($urandom_range(0, 3) == 0);
				// long hold-off so the count queue fills and push is refused
				if (results_seen == 20 || results_seen == 150)
					stall_left = HOLD_CYCLES;
				else
					stall_left = pick_gap(receiver_calm);
			end
			if (stall_left > 0) begin
				pop <= 1'b0;
				stall_left--;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
